>>> sv/vrm_pkg.sv
`timescale 1ns / 1ps
// vrm_pkg: shared widths, register indexes, reset values and structs
// for the windowed rms / mean voltmeter; no dependencies
package vrm_pkg;

	localparam int SAMPLE_BITS_DEF     = 12;
	localparam int MAX_WINDOW_LOG2_DEF = 8;

	localparam int SUM_W  = 40;
	localparam int FS_W   = 13;
	localparam int OFS_W  = 8;
	localparam int WLOG_W = 4;
	localparam int MV_W   = FS_W + 1;
	localparam int READ_W = 13;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = FS_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_RMS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOG2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_OFS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RMS_OFS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd4;

	// reset values
	localparam logic              MODE_RMS_RST    = 1'b0;
	localparam logic [WLOG_W-1:0] WINDOW_LOG2_RST = 4'd6;
	localparam logic [OFS_W-1:0]  MEAN_OFS_RST    = 8'd90;
	localparam logic [OFS_W-1:0]  RMS_OFS_RST     = 8'd100;
	localparam logic [FS_W-1:0]   FULL_SCALE_RST  = 13'd3300;

	localparam logic [READ_W-1:0] READING_MAX = '1;

	typedef struct packed {
		logic              mode_rms;
		logic [WLOG_W-1:0] window_log2;
		logic [OFS_W-1:0]  mean_offset_mv;
		logic [OFS_W-1:0]  rms_offset_mv;
		logic [FS_W-1:0]   full_scale_mv;
	} cfg_t;

	// one strobe per sequencer step
	typedef struct packed {
		logic take;
		logic scale;
		logic square;
		logic acc;
		logic shift;
		logic mean_mul;
		logic root_step;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic win_end;
		logic out_free;
	} stat_t;

endpackage

>>> sv/vrm_sample_if.sv
`timescale 1ns / 1ps
// vrm_sample_if: valid/ready channel carrying one converter sample
// depends on vrm_pkg
interface vrm_sample_if import vrm_pkg::*; #(
	parameter int W = SAMPLE_BITS_DEF
);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample_code;

	modport source (output valid, output sample_code, input ready);
	modport sink (input valid, input sample_code, output ready);
endinterface

>>> sv/vrm_reading_if.sv
`timescale 1ns / 1ps
// vrm_reading_if: valid/ready channel carrying one voltage reading
// depends on vrm_pkg
interface vrm_reading_if import vrm_pkg::*;;
	logic              valid;
	logic              ready;
	logic [READ_W-1:0] reading_mv;
	logic              reading_is_rms;

	modport source (output valid, output reading_mv, output reading_is_rms, input ready);
	modport sink (input valid, input reading_mv, input reading_is_rms, output ready);
endinterface

>>> sv/vrm_cfg_if.sv
`timescale 1ns / 1ps
// vrm_cfg_if: register write channel, index plus data
// depends on vrm_pkg
interface vrm_cfg_if import vrm_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/vrm_datapath.sv
`timescale 1ns / 1ps
// vrm_datapath: shared multiplier, window accumulator, digit-serial square root
// and output register; depends on vrm_pkg, driven by vrm_ctrl
module vrm_datapath import vrm_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   win_clr,
	input  ctrl_t                  ctrl,
	output stat_t                  stat,
	input  logic [SAMPLE_BITS-1:0] sample_code,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [READ_W-1:0]      reading_mv,
	output logic                   reading_is_rms
);

	localparam int KW     = $clog2(MAX_WINDOW_LOG2 + 1);
	localparam int CNT_W  = MAX_WINDOW_LOG2 + 1;
	localparam int MA_W   = (SAMPLE_BITS > MV_W) ? SAMPLE_BITS : MV_W;
	localparam int PROD_W = MA_W + MV_W;

	logic [SAMPLE_BITS-1:0] code_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       rad_q;
	logic [ROOT_W-1:0]      root_q;
	logic [REM_W-1:0]       rem_q;
	logic                   out_valid_q;
	logic [READ_W-1:0]      reading_q;
	logic                   is_rms_q;

	logic [KW-1:0]     k_eff;
	logic [CNT_W-1:0]  win_size;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [MA_W-1:0]   mul_a;
	logic [MV_W-1:0]   mul_b;
	logic [PROD_W-1:0] prod_d;
	logic [PROD_W-1:0] prod_shr;
	logic [MV_W-1:0]   mv_rms;
	logic [MV_W-1:0]   mv_mean;
	logic [SUM_W-1:0]  addend;
	logic [REM_W-1:0]  rem_in;
	logic [REM_W-1:0]  trial;
	logic              digit;
	logic [READ_W-1:0] root_sat;
	logic [READ_W-1:0] mean_sat;

	// window length, clamped
	assign k_eff = (cfg.window_log2 > WLOG_W'(MAX_WINDOW_LOG2)) ?
		KW'(MAX_WINDOW_LOG2) : cfg.window_log2[KW-1:0];
	assign win_size = CNT_W'(1) << k_eff;
	assign cnt_nxt  = cnt_q + CNT_W'(1);

	// scaled value from the last product: (x * full_scale) >> sample bits
	assign prod_shr = prod_q >> SAMPLE_BITS;
	assign mv_rms   = MV_W'(prod_shr[FS_W-1:0]) + MV_W'(cfg.rms_offset_mv);
	assign mv_mean  = MV_W'(prod_shr[FS_W-1:0]) + MV_W'(cfg.mean_offset_mv);

	// shared multiplier operand select
	always_comb begin
		if (ctrl.square) begin
			mul_a = MA_W'(mv_rms);
			mul_b = mv_rms;
		end else if (ctrl.mean_mul) begin
			mul_a = MA_W'(rad_q[SAMPLE_BITS-1:0]);
			mul_b = MV_W'(cfg.full_scale_mv);
		end else begin
			mul_a = MA_W'(code_q);
			mul_b = MV_W'(cfg.full_scale_mv);
		end
	end
	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign addend = cfg.mode_rms ? SUM_W'(prod_q) : SUM_W'(code_q);

	// one root digit per step
	assign rem_in = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign digit  = (rem_in >= trial);

	assign root_sat = (root_q > ROOT_W'(READING_MAX)) ? READING_MAX : root_q[READ_W-1:0];
	assign mean_sat = (mv_mean > MV_W'(READING_MAX)) ? READING_MAX : mv_mean[READ_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.take)
			code_q <= sample_code;
		if (ctrl.scale || ctrl.square || ctrl.mean_mul)
			prod_q <= prod_d;
		if (ctrl.shift) begin
			rad_q  <= sum_q >> k_eff;
			root_q <= '0;
			rem_q  <= '0;
		end else if (ctrl.root_step) begin
			rad_q  <= rad_q << 2;
			root_q <= {root_q[ROOT_W-2:0], digit};
			rem_q  <= digit ? (rem_in - trial) : rem_in;
		end
		if (ctrl.finish) begin
			reading_q <= cfg.mode_rms ? root_sat : mean_sat;
			is_rms_q  <= cfg.mode_rms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (win_clr) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (ctrl.acc) begin
				sum_q <= sum_q + addend;
				cnt_q <= stat.win_end ? '0 : cnt_nxt;
			end else if (ctrl.shift) begin
				sum_q <= '0;
			end
			if (ctrl.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.win_end  = (cnt_nxt == win_size);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign reading_mv     = reading_q;
	assign reading_is_rms = is_rms_q;

`ifndef SYNTHESIS
	// a waiting reading is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> (!out_valid_q || out_ready))
		else $error("reading loaded while previous one still pending");

	// the sample count stays inside the window
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < win_size)
		else $error("sample count reached window size");
`endif

endmodule

>>> sv/vrm_ctrl.sv
`timescale 1ns / 1ps
// vrm_ctrl: sequencer stepping the shared datapath through one sample
// and the window-end reading; depends on vrm_pkg
module vrm_ctrl import vrm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  mode_rms,
	input  stat_t stat,
	output ctrl_t ctrl
);

	localparam int IT_W = $clog2(ROOT_W);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCALE    = 3'd1;
	localparam logic [2:0] ST_SQUARE   = 3'd2;
	localparam logic [2:0] ST_ACC      = 3'd3;
	localparam logic [2:0] ST_SHIFT    = 3'd4;
	localparam logic [2:0] ST_MEAN_MUL = 3'd5;
	localparam logic [2:0] ST_ROOT     = 3'd6;
	localparam logic [2:0] ST_FINISH   = 3'd7;

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic [IT_W-1:0] it_q;

	assign in_ready = (state_q == ST_IDLE);

	assign ctrl.take      = (state_q == ST_IDLE) && in_valid;
	assign ctrl.scale     = (state_q == ST_SCALE);
	assign ctrl.square    = (state_q == ST_SQUARE);
	assign ctrl.acc       = (state_q == ST_ACC);
	assign ctrl.shift     = (state_q == ST_SHIFT);
	assign ctrl.mean_mul  = (state_q == ST_MEAN_MUL);
	assign ctrl.root_step = (state_q == ST_ROOT);
	assign ctrl.finish    = (state_q == ST_FINISH) && stat.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = mode_rms ? ST_SCALE : ST_ACC;
			end
			ST_SCALE:    state_d = ST_SQUARE;
			ST_SQUARE:   state_d = ST_ACC;
			ST_ACC:      state_d = stat.win_end ? ST_SHIFT : ST_IDLE;
			ST_SHIFT:    state_d = mode_rms ? ST_ROOT : ST_MEAN_MUL;
			ST_MEAN_MUL: state_d = ST_FINISH;
			ST_ROOT: begin
				if (it_q == IT_W'(ROOT_W - 1))
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free)
					state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.shift)
				it_q <= '0;
			else if (ctrl.root_step)
				it_q <= it_q + IT_W'(1);
		end
	end

`ifndef SYNTHESIS
	// a reading is only ever formed after a root pass or a mean scaling
	a_finish_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> ($past(state_q) == ST_ROOT ||
			$past(state_q) == ST_MEAN_MUL || $past(state_q) == ST_FINISH))
		else $error("finish entered from an unexpected step");
`endif

endmodule

>>> sv/windowed_rms_and_mean_voltmeter_top.sv
`timescale 1ns / 1ps
// windowed_rms_and_mean_voltmeter_top: register file, sequencer and datapath
// depends on vrm_pkg, vrm_sample_if, vrm_reading_if, vrm_cfg_if, vrm_ctrl, vrm_datapath
//
// usage
//   sample  : sink channel, one converter code per transaction
//   reading : source channel, one reading in mV per completed window of
//             2^window_log2 samples (capped at 2^MAX_WINDOW_LOG2), with a flag telling rms from mean
//   cfg     : register writes, always ready; writing mode_rms or window_log2
//             restarts the window, offsets and full scale act at once
// sample handling
//   one sample at a time, taken only while idle; mean mode accumulates it, rms mode
//   runs scale, then square on the single shared multiplier, then the accumulate step
// steps at window end
//   mean: shift, scale, finish; the reading is loaded at finish
//   rms : shift, the root pass with one root digit per cycle, then finish
//   the output register drives the port directly, with no further register
// reset: registers return to their defaults, window empty, no reading pending
// stall: a pending reading sits in the output register; the next sample is
//   still taken and only the next window end waits until the reading leaves
module windowed_rms_and_mean_voltmeter_top import vrm_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF
) (
	input logic           clk,
	input logic           arst_n,
	vrm_sample_if.sink    sample,
	vrm_reading_if.source reading,
	vrm_cfg_if.sink       cfg
);

	cfg_t  cfg_q;
	ctrl_t ctrl;
	stat_t stat;
	logic  cfg_wr;
	logic  win_clr;

	// configuration registers, never back-pressured
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// mode or window change starts a fresh window
	assign win_clr = cfg_wr && (cfg.index == CFG_MODE_RMS || cfg.index == CFG_WINDOW_LOG2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_rms       <= MODE_RMS_RST;
			cfg_q.window_log2    <= WINDOW_LOG2_RST;
			cfg_q.mean_offset_mv <= MEAN_OFS_RST;
			cfg_q.rms_offset_mv  <= RMS_OFS_RST;
			cfg_q.full_scale_mv  <= FULL_SCALE_RST;
		end else if (cfg_wr) begin
			case (cfg.index)
				CFG_MODE_RMS:    cfg_q.mode_rms       <= cfg.data[0];
				CFG_WINDOW_LOG2: cfg_q.window_log2    <= cfg.data[WLOG_W-1:0];
				CFG_MEAN_OFS:    cfg_q.mean_offset_mv <= cfg.data[OFS_W-1:0];
				CFG_RMS_OFS:     cfg_q.rms_offset_mv  <= cfg.data[OFS_W-1:0];
				CFG_FULL_SCALE:  cfg_q.full_scale_mv  <= cfg.data[FS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: one sample in flight, steps the shared unit
	vrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.mode_rms (cfg_q.mode_rms),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// multiplier, accumulator, square root and output register
	vrm_datapath #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.win_clr        (win_clr),
		.ctrl           (ctrl),
		.stat           (stat),
		.sample_code    (sample.sample_code),
		.out_valid      (reading.valid),
		.out_ready      (reading.ready),
		.reading_mv     (reading.reading_mv),
		.reading_is_rms (reading.reading_is_rms)
	);

`ifndef SYNTHESIS
	// one sample at a time: the channel closes right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample taken while another is in flight");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for windowed_rms_and_mean_voltmeter_top
// depends on vrm_pkg, vrm_sample_if, vrm_reading_if, vrm_cfg_if and the rtl under sv/
module tb_top;
	import vrm_pkg::*;

	localparam int          CLK_HALF       = 10;
	localparam int          RESET_CYCLES   = 11;
	localparam int          RANDOM_SAMPLES = 900;
	// covers the root pass plus the output register and margin
	localparam int          SETTLE_CYCLES  = 40;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned MAX_SHOWN      = 10;

	typedef enum int {
		FLOW_STEADY,
		FLOW_SENDER_IDLE,
		FLOW_RECEIVER_STALL,
		FLOW_BOTH_IDLE
	} flow_t;

	typedef struct packed {
		logic [READ_W-1:0] mv;
		logic              is_rms;
	} reading_t;

	// keeps its own copy of the registers and the window accumulator and
	// queues the reading each completed window must produce
	class reading_predictor;
		cfg_t              regs;
		logic [SUM_W-1:0]  window_sum;
		logic [8:0]        samples_seen;
		reading_t          pending_readings[$];
		int unsigned       mismatches;
		int unsigned       samples_taken;
		int unsigned       reg_writes;
		int unsigned       mean_readings;
		int unsigned       rms_readings;

		function new();
			regs.mode_rms       = MODE_RMS_RST;
			regs.window_log2    = WINDOW_LOG2_RST;
			regs.mean_offset_mv = MEAN_OFS_RST;
			regs.rms_offset_mv  = RMS_OFS_RST;
			regs.full_scale_mv  = FULL_SCALE_RST;
			clear_window();
		endfunction

		function void clear_window();
			window_sum   = '0;
			samples_seen = '0;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("tb_top: mismatch: %s", what);
		endfunction

		function logic [63:0] scale_mv(logic [63:0] code);
			return (code * 64'(regs.full_scale_mv)) >> SAMPLE_BITS_DEF;
		endfunction

		// floor square root, one result bit at a time from the top
		function logic [63:0] floor_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] trial;
			root = '0;
			for (int b = ROOT_W; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= v)
					root = trial;
			end
			return root;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				CFG_MODE_RMS: begin
					regs.mode_rms = data[0];
					clear_window();
				end
				CFG_WINDOW_LOG2: begin
					regs.window_log2 = data[WLOG_W-1:0];
					clear_window();
				end
				CFG_MEAN_OFS:   regs.mean_offset_mv = data[OFS_W-1:0];
				CFG_RMS_OFS:    regs.rms_offset_mv = data[OFS_W-1:0];
				CFG_FULL_SCALE: regs.full_scale_mv = data[FS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [SAMPLE_BITS_DEF-1:0] code);
			int unsigned k;
			logic [63:0] mv;
			logic [63:0] value;
			reading_t    r;
			samples_taken++;
			k = (int'(regs.window_log2) > MAX_WINDOW_LOG2_DEF) ? MAX_WINDOW_LOG2_DEF
				: int'(regs.window_log2);
			if (regs.mode_rms) begin
				mv = scale_mv(64'(code)) + 64'(regs.rms_offset_mv);
				window_sum = window_sum + SUM_W'(mv * mv);
			end else begin
				window_sum = window_sum + SUM_W'(code);
			end
			samples_seen = samples_seen + 9'd1;
			if (int'(samples_seen) < (1 << k))
				return;
			if (regs.mode_rms)
				value = floor_sqrt(64'(window_sum >> k));
			else
				value = scale_mv(64'(window_sum >> k)) + 64'(regs.mean_offset_mv);
			r.mv     = (value > 64'(READING_MAX)) ? READING_MAX : value[READ_W-1:0];
			r.is_rms = regs.mode_rms;
			pending_readings.push_back(r);
			clear_window();
		endfunction

		function void check_reading(logic [READ_W-1:0] mv, logic is_rms);
			reading_t want;
			if (pending_readings.size() == 0) begin
				flag($sformatf("reading %0d mV rms=%0b with none expected", mv, is_rms));
				return;
			end
			want = pending_readings.pop_front();
			if (want.is_rms)
				rms_readings++;
			else
				mean_readings++;
			if (mv !== want.mv || is_rms !== want.is_rms)
				flag($sformatf("reading expected %0d mV rms=%0b, got %0d mV rms=%0b",
					want.mv, want.is_rms, mv, is_rms));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	vrm_sample_if #(.W(SAMPLE_BITS_DEF)) sample_ch();
	vrm_reading_if                       reading_ch();
	vrm_cfg_if                           cfg_ch();

	windowed_rms_and_mean_voltmeter_top #(
		.SAMPLE_BITS    (SAMPLE_BITS_DEF),
		.MAX_WINDOW_LOG2(MAX_WINDOW_LOG2_DEF)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.reading(reading_ch),
		.cfg    (cfg_ch)
	);

	reading_predictor predictor = new();

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;

	always #(CLK_HALF) clk = ~clk;

	// sets how often the sample side idles and the reading side stalls
	function void set_flow(flow_t flow);
		case (flow)
			FLOW_STEADY: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			FLOW_SENDER_IDLE: begin
				send_idle_pct = 69;
				stall_pct     = 0;
			end
			FLOW_RECEIVER_STALL: begin
				send_idle_pct = 0;
				stall_pct     = 69;
			end
			default: begin
				send_idle_pct = 8;
				stall_pct     = 8;
			end
		endcase
	endfunction

	// reading side: check every accepted transaction, then pick next ready
	always @(posedge clk) begin
		if (arst_n && reading_ch.valid && reading_ch.ready)
			predictor.check_reading(reading_ch.reading_mv, reading_ch.reading_is_rms);
		reading_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog: any transaction on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (reading_ch.valid && reading_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one sample transaction, with optional idle cycles in front;
	// valid stays high on return so back-to-back samples need no gap
	task automatic push_sample(input logic [SAMPLE_BITS_DEF-1:0] code);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.sample_code <= code;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predictor.note_sample(code);
	endtask

	// one register write transaction, after which valid is dropped
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		predictor.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, wait for every queued reading, then let the datapath
	// finish any sample still in flight so a register write is safe
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (predictor.pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random register values lean on the range ends
	function automatic logic [OFS_W-1:0] pick_offset();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return OFS_W'($urandom);
		endcase
	endfunction

	function automatic logic [FS_W-1:0] pick_full_scale();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return FS_W'(1000);
			3:       return FS_W'(5000);
			default: return FS_W'($urandom_range(0, (1 << FS_W) - 1));
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS_DEF-1:0] pick_code();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return SAMPLE_BITS_DEF'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned                phase;
		int unsigned                k;
		int unsigned                count;
		int unsigned                random_sent;
		logic        [WLOG_W-1:0]   wlog;
		logic        [CFG_DATA_W-1:0] data;
		bit                         big_window;

		// every driven input known from time zero, ready follows the first edge
		arst_n                <= 1'b0;
		sample_ch.valid       <= 1'b0;
		sample_ch.sample_code <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= CFG_MODE_RMS;
		cfg_ch.data           <= '0;
		set_flow(FLOW_BOTH_IDLE);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: single-sample windows first, so each sample gives a reading
		// mean mode across the code range, no offset, widest full scale
		write_reg(CFG_MODE_RMS, CFG_DATA_W'(0));
		write_reg(CFG_WINDOW_LOG2, CFG_DATA_W'(0));
		write_reg(CFG_MEAN_OFS, CFG_DATA_W'(0));
		write_reg(CFG_FULL_SCALE, '1);
		push_sample('0);
		push_sample('1);
		push_sample(SAMPLE_BITS_DEF'(1));
		push_sample(SAMPLE_BITS_DEF'(12'h800));
		push_sample(SAMPLE_BITS_DEF'(12'haaa));
		push_sample(SAMPLE_BITS_DEF'(12'h555));
		drain();
		// mean reading pushed past the top of the range saturates
		write_reg(CFG_MEAN_OFS, CFG_DATA_W'(255));
		push_sample('1);
		drain();
		// zero full scale leaves only the offset
		write_reg(CFG_FULL_SCALE, '0);
		push_sample('1);
		push_sample('0);
		drain();
		// rms mode, no offset then full offset
		write_reg(CFG_MODE_RMS, CFG_DATA_W'(1));
		write_reg(CFG_RMS_OFS, CFG_DATA_W'(0));
		write_reg(CFG_FULL_SCALE, '1);
		push_sample('0);
		push_sample('1);
		push_sample(SAMPLE_BITS_DEF'(12'haaa));
		push_sample(SAMPLE_BITS_DEF'(12'h555));
		drain();
		write_reg(CFG_RMS_OFS, CFG_DATA_W'(255));
		push_sample('1);
		push_sample('0);
		drain();
		write_reg(CFG_FULL_SCALE, '0);
		push_sample(SAMPLE_BITS_DEF'(12'h07b));
		drain();
		// indexes past the last register must be ignored
		for (int j = 1; j <= 3; j++)
			write_reg(CFG_FULL_SCALE + CFG_IDX_W'(j), CFG_DATA_W'($urandom));
		// scale change in the middle of a window only hits later samples
		write_reg(CFG_WINDOW_LOG2, CFG_DATA_W'(1));
		write_reg(CFG_FULL_SCALE, CFG_DATA_W'(3300));
		write_reg(CFG_RMS_OFS, CFG_DATA_W'(100));
		push_sample(SAMPLE_BITS_DEF'(12'hfff));
		push_sample(SAMPLE_BITS_DEF'(12'h123));
		push_sample(SAMPLE_BITS_DEF'(12'h9c4));
		drain();
		write_reg(CFG_FULL_SCALE, CFG_DATA_W'(5000));
		push_sample(SAMPLE_BITS_DEF'(12'h3e8));
		drain();
		// mode write halfway through a window throws the partial sum away
		write_reg(CFG_WINDOW_LOG2, CFG_DATA_W'(2));
		push_sample('1);
		drain();
		write_reg(CFG_MODE_RMS, CFG_DATA_W'(0));
		push_sample(SAMPLE_BITS_DEF'(12'h010));
		push_sample(SAMPLE_BITS_DEF'(12'h020));
		push_sample(SAMPLE_BITS_DEF'(12'h030));
		push_sample(SAMPLE_BITS_DEF'(12'h041));
		drain();

		// ---- random phases; each starts from an idle block, which also
		// makes the sender wait out every pending reading at least once
		phase       = 0;
		random_sent = 0;
		while (random_sent < RANDOM_SAMPLES) begin
			set_flow(flow_t'(phase % 4));
			big_window = (phase == 2 || phase == 7);
			if (phase == 0) begin
				// back to the power-on settings
				write_reg(CFG_MODE_RMS, CFG_DATA_W'(MODE_RMS_RST));
				write_reg(CFG_WINDOW_LOG2, CFG_DATA_W'(WINDOW_LOG2_RST));
				write_reg(CFG_MEAN_OFS, CFG_DATA_W'(MEAN_OFS_RST));
				write_reg(CFG_RMS_OFS, CFG_DATA_W'(RMS_OFS_RST));
				write_reg(CFG_FULL_SCALE, CFG_DATA_W'(FULL_SCALE_RST));
			end else begin
				if (phase == 2)
					wlog = WLOG_W'(MAX_WINDOW_LOG2_DEF);
				else if (phase == 7)
					// above the maximum, taken as the maximum
					wlog = WLOG_W'($urandom_range(MAX_WINDOW_LOG2_DEF + 1, (1 << WLOG_W) - 1));
				else if ($urandom_range(0, 4) == 0)
					wlog = WLOG_W'($urandom_range(4, 7));
				else
					wlog = WLOG_W'($urandom_range(0, 3));
				// upper data bits carry junk the narrow registers must drop
				if ($urandom_range(0, 9) < 5 || big_window) begin
					data    = CFG_DATA_W'($urandom);
					data[0] = 1'($urandom_range(0, 1));
					write_reg(CFG_MODE_RMS, data);
				end
				if ($urandom_range(0, 9) < 7 || big_window) begin
					data               = CFG_DATA_W'($urandom);
					data[WLOG_W-1:0]   = wlog;
					write_reg(CFG_WINDOW_LOG2, data);
				end
				if ($urandom_range(0, 1) == 0) begin
					data              = CFG_DATA_W'($urandom);
					data[OFS_W-1:0]   = pick_offset();
					write_reg(CFG_MEAN_OFS, data);
				end
				if ($urandom_range(0, 1) == 0) begin
					data              = CFG_DATA_W'($urandom);
					data[OFS_W-1:0]   = pick_offset();
					write_reg(CFG_RMS_OFS, data);
				end
				if ($urandom_range(0, 1) == 0)
					write_reg(CFG_FULL_SCALE, pick_full_scale());
				if ($urandom_range(0, 9) == 0)
					write_reg(CFG_FULL_SCALE + CFG_IDX_W'($urandom_range(1, 3)),
						CFG_DATA_W'($urandom));
			end

			k = (int'(predictor.regs.window_log2) > MAX_WINDOW_LOG2_DEF) ? MAX_WINDOW_LOG2_DEF
				: int'(predictor.regs.window_log2);
			// short windows get several readings and a partial tail,
			// long ones a single window and a few spare samples
			if (k >= 4)
				count = (1 << k) + $urandom_range(0, 7);
			else
				count = $urandom_range(1, 4) * (1 << k) + $urandom_range(0, (1 << k) - 1);
			repeat (count) begin
				push_sample(pick_code());
				random_sent++;
			end
			drain();
			phase++;
		end

		// drain() has already waited for the last reading plus settle time
		$display("tb_top: %0d samples in %0d random phases, %0d register writes",
			predictor.samples_taken, phase, predictor.reg_writes);
		$display("tb_top: %0d mean and %0d rms readings checked, %0d mismatches",
			predictor.mean_readings, predictor.rms_readings, predictor.mismatches);
		if (predictor.mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

>>> files.f
sv/vrm_pkg.sv
sv/vrm_sample_if.sv
sv/vrm_reading_if.sv
sv/vrm_cfg_if.sv
sv/vrm_datapath.sv
sv/vrm_ctrl.sv
sv/windowed_rms_and_mean_voltmeter_top.sv
verif/tb_top.sv
